>>> hw/rtl/tss_pkg.sv
// Shared constants for the tilt sensor SPI sampler: command bytes, codes and widths.
package tss_pkg;

	localparam int unsigned CountW   = 10;
	localparam int unsigned TempSumW = 18;
	localparam int unsigned AxisSumW = 21;
	localparam int unsigned AxisW    = 11;

	localparam logic [CountW-1:0] SAMPLE_COUNT_RST = 10'd200;

	// Command bytes sent to the sensor
	localparam logic [7:0] CMD_TEMP  = 8'h08;
	localparam logic [7:0] CMD_Y     = 8'h11;
	localparam logic [7:0] CMD_X     = 8'h10;
	localparam logic [7:0] CMD_DUMMY = 8'h00;

	// Transfer phase codes
	localparam logic [1:0] PH_CMD    = 2'd0;
	localparam logic [1:0] PH_FIRST  = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;

	// Channel codes
	localparam logic [1:0] CH_TEMP = 2'd0;
	localparam logic [1:0] CH_Y    = 2'd1;
	localparam logic [1:0] CH_X    = 2'd2;

	// Input event kinds
	localparam logic EV_START = 1'b0;
	localparam logic EV_BYTE  = 1'b1;

endpackage

>>> hw/rtl/spi_tilt_sensor_sampler.sv
// Top level of the tilt sensor SPI sampler: input register, sequencer update and result register.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+--------------------------------------------------------
//  in      | in_valid / in_ready   | kind, rx_byte
//  out     | out_valid / out_ready | tx_valid, tx_byte, frame_end, sums_valid,
//          |                       | x_sum, y_sum, temp_sum
//  cfg     | cfg_valid / cfg_ready | cfg_data (sample_count)
//
// Each beat passes through the input register, then through the phase and accumulator update into the
// result register. A new beat can enter every cycle while the result register can move on.
// The accumulator add and the count compare lie between the two registers.
// Reset clears the phase machine, the sums and the count, and loads the default sample count.
// When the result is not taken, the input register holds one further beat, then in_ready drops.
module spi_tilt_sensor_sampler (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             kind,
	input  logic [7:0]                       rx_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             tx_valid,
	output logic [7:0]                       tx_byte,
	output logic                             frame_end,
	output logic                             sums_valid,
	output logic [tss_pkg::AxisSumW-1:0]     x_sum,
	output logic [tss_pkg::AxisSumW-1:0]     y_sum,
	output logic [tss_pkg::TempSumW-1:0]     temp_sum,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tss_pkg::CountW-1:0]       cfg_data
);
	import tss_pkg::*;

	// Input register
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] rx_s1;

	// Result register
	logic                valid_s2;
	logic                tx_valid_s2;
	logic [7:0]          tx_byte_s2;
	logic                frame_end_s2;
	logic                sums_valid_s2;
	logic [AxisSumW-1:0] x_sum_s2;
	logic [AxisSumW-1:0] y_sum_s2;
	logic [TempSumW-1:0] temp_sum_s2;

	// Sequencer state
	logic [CountW-1:0]   sample_count_q;
	logic [1:0]          phase_q;
	logic [1:0]          chan_q;
	logic [7:0]          high_byte_q;
	logic [TempSumW-1:0] temp_acc_q;
	logic [AxisSumW-1:0] y_acc_q;
	logic [AxisSumW-1:0] x_acc_q;
	logic [CountW-1:0]   count_q;

	logic s2_free;
	logic s1_adv;

	assign s2_free   = !valid_s2 || out_ready;
	assign s1_adv    = valid_s1 && s2_free;
	assign in_ready  = !valid_s1 || s2_free;
	assign cfg_ready = 1'b1;

	// Next-state and result logic for the beat in the input register
	logic [1:0]          phase_nx;
	logic [1:0]          chan_nx;
	logic [7:0]          high_nx;
	logic                finished;
	logic                r_tx_valid;
	logic [7:0]          r_tx_byte;
	logic [AxisW-1:0]    axis_rd;
	logic [TempSumW-1:0] temp_add;
	logic [AxisSumW-1:0] y_add;
	logic [AxisSumW-1:0] x_add;
	logic [CountW-1:0]   count_inc;
	logic                emit;

	assign axis_rd = {high_byte_q, rx_s1[7:5]};

	always_comb begin
		phase_nx   = phase_q;
		chan_nx    = chan_q;
		high_nx    = high_byte_q;
		finished   = 1'b0;
		r_tx_valid = 1'b0;
		r_tx_byte  = CMD_DUMMY;
		if (kind_s1 == EV_START) begin
			phase_nx   = PH_CMD;
			chan_nx    = CH_TEMP;
			r_tx_valid = 1'b1;
			r_tx_byte  = CMD_TEMP;
		end else begin
			unique case (phase_q)
				PH_FIRST: begin
					high_nx = rx_s1;
					if (chan_q == CH_TEMP) begin
						finished = 1'b1;
					end else begin
						phase_nx   = PH_SECOND;
						r_tx_valid = 1'b1;
					end
				end
				PH_SECOND: begin
					finished = 1'b1;
				end
				default: begin
					// A command has gone out; clock in the first data byte.
					phase_nx   = PH_FIRST;
					r_tx_valid = 1'b1;
				end
			endcase
		end

		temp_add  = temp_acc_q;
		y_add     = y_acc_q;
		x_add     = x_acc_q;
		count_inc = count_q;
		if (finished) begin
			phase_nx   = PH_CMD;
			r_tx_valid = 1'b1;
			unique case (chan_q)
				CH_TEMP: begin
					temp_add  = temp_acc_q + TempSumW'(rx_s1);
					chan_nx   = CH_Y;
					r_tx_byte = CMD_Y;
				end
				CH_Y: begin
					y_add     = y_acc_q + AxisSumW'(axis_rd);
					chan_nx   = CH_X;
					r_tx_byte = CMD_X;
				end
				CH_X: begin
					x_add     = x_acc_q + AxisSumW'(axis_rd);
					count_inc = count_q + CountW'(1);
					chan_nx   = CH_TEMP;
					r_tx_byte = CMD_TEMP;
				end
				default: begin
					chan_nx   = CH_TEMP;
					r_tx_byte = CMD_TEMP;
				end
			endcase
		end
		emit = finished && (count_inc >= sample_count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			sample_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			rx_s1   <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CMD;
			chan_q      <= CH_TEMP;
			high_byte_q <= '0;
			temp_acc_q  <= '0;
			y_acc_q     <= '0;
			x_acc_q     <= '0;
			count_q     <= '0;
		end else if (s1_adv) begin
			phase_q     <= phase_nx;
			chan_q      <= chan_nx;
			high_byte_q <= high_nx;
			temp_acc_q  <= emit ? '0 : temp_add;
			y_acc_q     <= emit ? '0 : y_add;
			x_acc_q     <= emit ? '0 : x_add;
			count_q     <= emit ? '0 : count_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			tx_valid_s2   <= r_tx_valid;
			tx_byte_s2    <= r_tx_byte;
			frame_end_s2  <= finished;
			sums_valid_s2 <= emit;
			x_sum_s2      <= emit ? x_add : '0;
			y_sum_s2      <= emit ? y_add : '0;
			temp_sum_s2   <= emit ? temp_add : '0;
		end
	end

	assign out_valid  = valid_s2;
	assign tx_valid   = tx_valid_s2;
	assign tx_byte    = tx_byte_s2;
	assign frame_end  = frame_end_s2;
	assign sums_valid = sums_valid_s2;
	assign x_sum      = x_sum_s2;
	assign y_sum      = y_sum_s2;
	assign temp_sum   = temp_sum_s2;

	// Sums are only released at the end of a reading, which always sends a command.
	a_sums_at_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sums_valid |-> frame_end && tx_valid)
		else $error("sums released outside a frame end");

	// An idle transmit slot carries the dummy code and no frame end.
	a_idle_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == CMD_DUMMY && !frame_end)
		else $error("idle transmit slot carries data");

	// A start beat always returns the sequencer to the temperature command.
	a_start_resets: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && kind_s1 == EV_START |=> phase_q == PH_CMD && chan_q == CH_TEMP)
		else $error("start did not restart the sequence");

	// The channel rotation never reaches the unused code.
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		chan_q == CH_TEMP || chan_q == CH_Y || chan_q == CH_X)
		else $error("channel left its rotation");

endmodule
